@@ src/blw_pkg.sv @@
`default_nettype none
package blw_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned CamW   = 13;
  localparam int unsigned ViewW  = 9;
  localparam int unsigned RangeW = 8;
  localparam int unsigned ScrW   = 8;
  localparam int unsigned DeltaW = 7;
  localparam int unsigned ErrW   = 9;
  localparam int unsigned CfgIdxW = 3;

  // Largest visible extent: screen coordinates are eight bits wide.
  localparam logic [ViewW-1:0] ViewMax = 9'd256;

  localparam logic [CfgIdxW-1:0] CfgCameraX     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCameraY     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgViewWidth   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgViewHeight  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWeaponRange = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [ScrW-1:0] view_col;
    logic [ScrW-1:0] view_row;
    logic            point_valid;
    logic            in_range;
    logic            too_far;
    logic            last;
  } out_t;

endpackage
`default_nettype wire

@@ src/bresenham_line_walker.sv @@
`default_nettype none
// One point is stepped per cycle by the shared step unit, except while the output side
// stalls, and the next line is accepted once the walk has finished. A line wider than
// MAX_SPAN, or one whose end points coincide, yields only its terminator.
// Reset is asynchronous and active low; it returns the configuration registers, the
// output valid flag and the point counter to their defaults and the sequencer to
// idle; the payload and walk registers are not reset.
module bresenham_line_walker
  import blw_pkg::*;
#(
  parameter int unsigned MAX_SPAN = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CamW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = (MAX_SPAN > 2) ? $clog2(MAX_SPAN) : 1;
  localparam logic [CntW-1:0] CntCap = CntW'(MAX_SPAN - 1);
  localparam logic [CoordW-1:0] SpanLimit = CoordW'(MAX_SPAN);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StFirst = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;
  localparam logic [2:0] StTerm  = 3'd4;

  logic [2:0] state_q, state_d;

  logic signed [CamW-1:0] cam_x_q, cam_y_q;
  logic [ViewW-1:0]       view_w_q, view_h_q;
  logic [RangeW-1:0]      range_q;

  logic [CoordW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [CoordW-1:0] lx_q, ly_q, lx_d, ly_d;
  logic [DeltaW-1:0] dx_q, dy_q;
  logic              sx_neg_q, sy_neg_q;
  logic [ErrW-1:0]   err_q, err_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              far_q;

  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  wire in_acc  = in_valid_i && in_ready_o;
  wire out_free = !out_valid_q || out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q  <= '0;
      cam_y_q  <= '0;
      view_w_q <= 9'd80;
      view_h_q <= 9'd24;
      range_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCameraX:     cam_x_q  <= cfg_data_i;
        CfgCameraY:     cam_y_q  <= cfg_data_i;
        CfgViewWidth:   view_w_q <= cfg_data_i[ViewW-1:0];
        CfgViewHeight:  view_h_q <= cfg_data_i[ViewW-1:0];
        CfgWeaponRange: range_q  <= cfg_data_i[RangeW-1:0];
        default: ;
      endcase
    end
  end

  // Spans taken from the captured end points.
  logic [CoordW-1:0] adx, ady;
  assign adx = (x1_q >= x0_q) ? (x1_q - x0_q) : (x0_q - x1_q);
  assign ady = (y1_q >= y0_q) ? (y1_q - y0_q) : (y0_q - y1_q);

  wire span_far = (adx > SpanLimit) || (ady > SpanLimit);
  wire same_pt  = (x0_q == x1_q) && (y0_q == y1_q);

  // Shared step unit.
  logic signed [ErrW:0]   e2;
  logic signed [ErrW:0]   dx_s, dy_s;
  logic                   step_x, step_y;
  logic [CoordW-1:0]      lx_step, ly_step;
  logic [ErrW-1:0]        err_step;

  assign e2   = {err_q, 1'b0};
  assign dx_s = signed'({{(ErrW + 1 - DeltaW){1'b0}}, dx_q});
  assign dy_s = signed'({{(ErrW + 1 - DeltaW){1'b0}}, dy_q});

  always_comb begin
    step_x   = e2 > -dy_s;
    step_y   = e2 < dx_s;
    err_step = err_q - (step_x ? dy_s[ErrW-1:0] : '0) + (step_y ? dx_s[ErrW-1:0] : '0);
    lx_step  = lx_q;
    ly_step  = ly_q;
    if (step_x) lx_step = sx_neg_q ? (lx_q - CoordW'(1)) : (lx_q + CoordW'(1));
    if (step_y) ly_step = sy_neg_q ? (ly_q - CoordW'(1)) : (ly_q + CoordW'(1));
  end

  // Evaluation of the current point against the view and the weapon range.
  logic signed [CamW:0] scx, scy;
  logic [ViewW-1:0]     vw, vh;
  logic                 visible;
  logic [CoordW-1:0]    ddx, ddy, cheb;
  logic                 inr;

  always_comb begin
    scx     = signed'({2'b00, lx_q}) - signed'({cam_x_q[CamW-1], cam_x_q});
    scy     = signed'({2'b00, ly_q}) - signed'({cam_y_q[CamW-1], cam_y_q});
    vw      = (view_w_q > ViewMax) ? ViewMax : view_w_q;
    vh      = (view_h_q > ViewMax) ? ViewMax : view_h_q;
    visible = !scx[CamW] && !scy[CamW] &&
              (unsigned'(scx) < {{(CamW + 1 - ViewW){1'b0}}, vw}) &&
              (unsigned'(scy) < {{(CamW + 1 - ViewW){1'b0}}, vh});
    ddx     = (lx_q >= x0_q) ? (lx_q - x0_q) : (x0_q - lx_q);
    ddy     = (ly_q >= y0_q) ? (ly_q - y0_q) : (y0_q - ly_q);
    cheb    = (ddx > ddy) ? ddx : ddy;
    inr     = (range_q != '0) && (cheb <= {{(CoordW - RangeW){1'b0}}, range_q});
  end

  wire at_target = (lx_q == x1_q) && (ly_q == y1_q);

  always_comb begin
    state_d     = state_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = StSetup;
      end
      StSetup: begin
        lx_d  = x0_q;
        ly_d  = y0_q;
        cnt_d = '0;
        err_d = ErrW'({1'b0, adx[DeltaW-1:0]}) - ErrW'({1'b0, ady[DeltaW-1:0]});
        if (span_far || same_pt) state_d = StTerm;
        else                     state_d = StFirst;
      end
      StFirst: begin
        lx_d    = lx_step;
        ly_d    = ly_step;
        err_d   = err_step;
        state_d = StWalk;
      end
      StWalk: begin
        if (at_target || (cnt_q == CntCap)) begin
          if (out_free) begin
            out_d       = '{view_col: '0, view_row: '0, point_valid: 1'b0,
                            in_range: 1'b0, too_far: 1'b0, last: 1'b1};
            out_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end else if (visible) begin
          if (out_free) begin
            out_d       = '{view_col: scx[ScrW-1:0], view_row: scy[ScrW-1:0],
                            point_valid: 1'b1, in_range: inr, too_far: 1'b0,
                            last: 1'b0};
            out_valid_d = 1'b1;
            cnt_d       = cnt_q + CntW'(1);
            lx_d        = lx_step;
            ly_d        = ly_step;
            err_d       = err_step;
          end
        end else begin
          lx_d  = lx_step;
          ly_d  = ly_step;
          err_d = err_step;
        end
      end
      StTerm: begin
        if (out_free) begin
          out_d       = '{view_col: '0, view_row: '0, point_valid: 1'b0,
                          in_range: 1'b0, too_far: far_q, last: 1'b1};
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    lx_q  <= lx_d;
    ly_q  <= ly_d;
    err_q <= err_d;
    if (in_acc) begin
      x0_q <= in_data_i.origin_x;
      y0_q <= in_data_i.origin_y;
      x1_q <= in_data_i.end_x;
      y1_q <= in_data_i.end_y;
    end
    if (state_q == StSetup) begin
      dx_q     <= adx[DeltaW-1:0];
      dy_q     <= ady[DeltaW-1:0];
      sx_neg_q <= !(x0_q < x1_q);
      sy_neg_q <= !(y0_q < y1_q);
      far_q    <= span_far;
    end
  end

endmodule
`default_nettype wire

@@ tb/bresenham_line_walker_tb.sv @@
`timescale 1ns / 100ps

module bresenham_line_walker_tb
  import blw_pkg::*;
();

  localparam int SpanMax = 64;
  localparam int CoordMax = 4095;
  localparam int CycleLimit = 3_000_000;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd5;

  class line_board;
    out_t pending_points[$];
    int cam_x;
    int cam_y;
    int view_w;
    int view_h;
    int reach;
    int mismatches;

    function new();
      cam_x = 0;
      cam_y = 0;
      view_w = 80;
      view_h = 24;
      reach = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CamW-1:0] data);
      case (idx)
        CfgCameraX: cam_x = int'($signed(data));
        CfgCameraY: cam_y = int'($signed(data));
        CfgViewWidth: view_w = int'(data[ViewW-1:0]);
        CfgViewHeight: view_h = int'(data[ViewW-1:0]);
        CfgWeaponRange: reach = int'(data[RangeW-1:0]);
        default: ;
      endcase
    endfunction

    // Queues up to SpanMax - 1 visible points of the line, then the closing word.
    function void add_line(in_t d);
      int x0, y0, x1, y1, dx, dy, sx, sy, vw, vh;
      int err, e2, lx, ly, scx, scy, ddx, ddy, cheb, n;
      out_t w;
      x0 = int'(d.origin_x);
      y0 = int'(d.origin_y);
      x1 = int'(d.end_x);
      y1 = int'(d.end_y);
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      vw = (view_w > 256) ? 256 : view_w;
      vh = (view_h > 256) ? 256 : view_h;
      w = '0;
      w.last = 1'b1;
      if (dx > SpanMax || dy > SpanMax) begin
        w.too_far = 1'b1;
        pending_points.push_back(w);
        return;
      end
      err = dx - dy;
      lx = x0;
      ly = y0;
      n = 0;
      while ((lx != x1 || ly != y1) && n < SpanMax - 1) begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          lx += sx;
        end
        if (e2 < dx) begin
          err += dx;
          ly += sy;
        end
        if (lx == x1 && ly == y1) break;
        scx = lx - cam_x;
        scy = ly - cam_y;
        if (scx >= 0 && scx < vw && scy >= 0 && scy < vh) begin
          ddx = (lx > x0) ? lx - x0 : x0 - lx;
          ddy = (ly > y0) ? ly - y0 : y0 - ly;
          cheb = (ddx > ddy) ? ddx : ddy;
          w = '0;
          w.view_col = ScrW'(scx);
          w.view_row = ScrW'(scy);
          w.point_valid = 1'b1;
          w.in_range = (reach > 0 && cheb <= reach);
          pending_points.push_back(w);
          n++;
        end
      end
      w = '0;
      w.last = 1'b1;
      pending_points.push_back(w);
    endfunction

    function void compare_field(string field, int want, int seen);
      if (want != seen) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: word expected none, got %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      compare_field("view_col", int'(want.view_col), int'(got.view_col));
      compare_field("view_row", int'(want.view_row), int'(got.view_row));
      compare_field("point_valid", int'(want.point_valid), int'(got.point_valid));
      compare_field("in_range", int'(want.in_range), int'(got.in_range));
      compare_field("too_far", int'(want.too_far), int'(got.too_far));
      compare_field("last", int'(want.last), int'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t in_data = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CamW-1:0] cfg_data = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  logic cfg_ready;

  line_board board;
  bit steady_run = 1'b0;
  int cycle_count = 0;

  bresenham_line_walker #(.MAX_SPAN(SpanMax)) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Inputs only change at rising edges, so the falling edge sees settled values.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_word(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_run) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 45) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 20));
  endfunction

  initial begin
    int gap;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > CoordMax) return CoordMax;
    return v;
  endfunction

  // Mostly lines that start near the view and stay within the span limit.
  function automatic in_t make_line(int cx, int cy, int vw, int vh);
    in_t d;
    int kind, ox, oy, dx, dy;
    kind = int'($urandom_range(0, 99));
    if (kind < 8) begin
      d.origin_x = CoordW'($urandom_range(0, CoordMax));
      d.origin_y = CoordW'($urandom_range(0, CoordMax));
      d.end_x = CoordW'($urandom_range(0, CoordMax));
      d.end_y = CoordW'($urandom_range(0, CoordMax));
      return d;
    end
    ox = clamp_coord(cx + int'($urandom_range(0, vw + 40)) - 20);
    oy = clamp_coord(cy + int'($urandom_range(0, vh + 40)) - 20);
    if (kind < 14) begin
      dx = 0;
      dy = 0;
    end else if (kind < 24) begin
      dx = int'($urandom_range(62, 67));
      if ($urandom_range(0, 1)) dx = -dx;
      dy = int'($urandom_range(0, 134)) - 67;
      if ($urandom_range(0, 1)) begin
        kind = dx;
        dx = dy;
        dy = kind;
      end
    end else begin
      dx = int'($urandom_range(0, 128)) - 64;
      dy = int'($urandom_range(0, 128)) - 64;
    end
    d.origin_x = CoordW'(ox);
    d.origin_y = CoordW'(oy);
    d.end_x = CoordW'(clamp_coord(ox + dx));
    d.end_y = CoordW'(clamp_coord(oy + dy));
    return d;
  endfunction

  task automatic send_line(in_t d);
    bit seen;
    int gap;
    in_data <= d;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      seen = in_ready;
      @(posedge clk);
    end while (!seen);
    board.add_line(d);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CamW-1:0] data);
    bit seen;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      seen = cfg_ready;
      @(posedge clk);
    end while (!seen);
    board.set_reg(idx, data);
  endtask

  task automatic drain();
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int cx, int cy, int vw, int vh, int rng, int lines, bit steady);
    logic [CamW-1:0] word;
    drain();
    steady_run = steady;
    write_reg(CfgSpare, CamW'($urandom));
    write_reg(CfgCameraX, CamW'(cx));
    write_reg(CfgCameraY, CamW'(cy));
    // Upper bits above each field are filled at random; the block must drop them.
    word = CamW'($urandom);
    word[ViewW-1:0] = ViewW'(vw);
    write_reg(CfgViewWidth, word);
    word = CamW'($urandom);
    word[ViewW-1:0] = ViewW'(vh);
    write_reg(CfgViewHeight, word);
    word = CamW'($urandom);
    word[RangeW-1:0] = RangeW'(rng);
    write_reg(CfgWeaponRange, word);
    cfg_valid <= 1'b0;
    repeat (lines) begin
      send_line(make_line(cx, cy, (vw > 256) ? 256 : vw, (vh > 256) ? 256 : vh));
    end
    in_valid <= 1'b0;
  endtask

  task automatic send_coords(int x0, int y0, int x1, int y1);
    in_t d;
    d.origin_x = CoordW'(x0);
    d.origin_y = CoordW'(y0);
    d.end_x = CoordW'(x1);
    d.end_y = CoordW'(y1);
    send_line(d);
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: camera at the map corner, an 80 by 24 view, nothing in range.
    send_coords(5, 5, 5, 5);
    send_coords(0, 0, 10, 3);
    send_coords(10, 3, 0, 0);
    send_coords(0, 0, 64, 0);
    send_coords(0, 0, 65, 0);
    send_coords(3, 0, 3, 23);
    send_coords(0, 0, 0, 65);
    send_coords(0, 0, 20, 20);
    send_coords(40, 20, 20, 2);
    send_coords(CoordMax, CoordMax, CoordMax - 64, CoordMax - 64);
    send_coords(0, 0, CoordMax, CoordMax);
    send_coords(CoordMax, 0, 0, CoordMax);
    send_coords(70, 10, 90, 12);
    send_coords(10, 30, 12, 10);
    send_coords(2, 1, 1, 2);
    send_coords(0, 0, 1, 0);
    send_coords(60, 23, 0, 0);
    in_valid <= 1'b0;

    run_phase(-10, -5, 256, 256, 255, 30, 1'b0);
    run_phase(0, 0, 80, 24, 5, 30, 1'b0);
    run_phase(-4096, -4096, 256, 256, 1, 12, 1'b1);
    run_phase(4095, 4000, 511, 256, 0, 30, 1'b0);
    run_phase(500, 500, 0, 50, 10, 15, 1'b0);
    run_phase(100, 200, 511, 511, 64, 30, 1'b0);
    run_phase(1000, 3000, 40, 30, 20, 30, 1'b1);
    run_phase(2048, 1024, 200, 100, 128, 30, 1'b0);
    run_phase(-100, 50, 150, 1, 32, 30, 1'b0);
    run_phase(3500, 3900, 256, 196, 255, 30, 1'b0);
    run_phase(30, 40, 1, 256, 3, 30, 1'b0);

    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.mismatches == 0 && board.pending_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
